[rtl/core/framed_command_parser_defines.svh]
// Assertion macros shared by the framed command parser RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef FRAMED_COMMAND_PARSER_DEFINES_SVH
`define FRAMED_COMMAND_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define FCP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define FCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FCP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define FCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/fcp_pkg.sv]
// Package for the framed command parser: types, character constants and
// the keyword lookup. No dependencies.
`default_nettype none

package fcp_pkg;

    localparam int unsigned KEYWORD_LEN = 4;
    localparam int unsigned MAX_DIGITS  = 9;
    localparam int unsigned MAX_BODY    = 255;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [7:0] START_CHAR_RESET = 8'd35;
    localparam logic [7:0] END_CHAR_RESET   = 8'd10;

    localparam logic [31:0] KW_CONT = 32'h434F_4E54;
    localparam logic [31:0] KW_EXTD = 32'h4558_5444;
    localparam logic [31:0] KW_STOP = 32'h5354_4F50;
    localparam logic [31:0] KW_PRNT = 32'h5052_4E54;

    typedef enum logic [2:0] {
        CMD_UNDEF = 3'd0,
        CMD_CONT  = 3'd1,
        CMD_EXTD  = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_PRNT  = 3'd4
    } cmd_t;

    typedef enum logic [0:0] {
        CFG_START_CHAR = 1'b0,
        CFG_END_CHAR   = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]         body_length;
        logic signed [30:0] value;
        logic               is_numeric;
        cmd_t               cmd_type;
    } fcp_result_t;

    function automatic cmd_t kw_lookup(input logic [31:0] kw);
        cmd_t c;
        c = CMD_UNDEF;
        if (kw == KW_CONT)      c = CMD_CONT;
        else if (kw == KW_EXTD) c = CMD_EXTD;
        else if (kw == KW_STOP) c = CMD_STOP;
        else if (kw == KW_PRNT) c = CMD_PRNT;
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/core/fcp_body.sv]
// Frame tracker and per-byte body parser; forms the result on the closing byte.
// Depends on fcp_pkg and framed_command_parser_defines.svh.
`default_nettype none
`include "framed_command_parser_defines.svh"

module fcp_body
    import fcp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        take,
    input  wire logic [7:0]  byte_in,
    input  wire logic [7:0]  start_char,
    input  wire logic [7:0]  end_char,
    output logic             res_valid,
    output fcp_result_t      res
);

    localparam logic [7:0] KwLen    = 8'(KEYWORD_LEN);
    localparam logic [7:0] MaxBody  = 8'(MAX_BODY);
    localparam logic [3:0] MaxDig   = 4'(MAX_DIGITS);

    logic        in_frame_reg,    in_frame_next;
    logic [7:0]  body_count_reg,  body_count_next;
    logic [31:0] kw_shift_reg,    kw_shift_next;
    logic [29:0] magnitude_reg,   magnitude_next;
    logic        minus_seen_reg,  minus_seen_next;
    logic        digits_ok_reg,   digits_ok_next;
    logic [3:0]  digit_count_reg, digit_count_next;

    logic        is_end;
    logic        is_digit;
    logic [3:0]  digit_val;
    logic [29:0] mag_times_ten;
    cmd_t        cmd;
    logic        numeric;
    logic [30:0] mag_ext;

    assign is_end    = (byte_in == end_char);
    assign is_digit  = (byte_in >= CHAR_ZERO) && (byte_in <= CHAR_NINE);
    assign digit_val = 4'(byte_in - CHAR_ZERO);
    assign mag_times_ten = 30'({magnitude_reg, 3'b000} + {magnitude_reg, 1'b0});

    // Result for a frame closed by the current byte.
    assign cmd     = (body_count_reg >= KwLen) ? kw_lookup(kw_shift_reg) : CMD_UNDEF;
    assign numeric = (cmd != CMD_UNDEF) && digits_ok_reg && (digit_count_reg <= MaxDig);
    assign mag_ext = {1'b0, magnitude_reg};

    always_comb
    begin
        res_valid       = take && in_frame_reg && is_end;
        res.cmd_type    = cmd;
        res.is_numeric  = numeric;
        res.body_length = body_count_reg;
        if (!numeric)
        begin
            res.value = '0;
        end
        else if (minus_seen_reg)
        begin
            res.value = 31'd0 - mag_ext;
        end
        else
        begin
            res.value = mag_ext;
        end
    end

    always_comb
    begin
        in_frame_next    = in_frame_reg;
        body_count_next  = body_count_reg;
        kw_shift_next    = kw_shift_reg;
        magnitude_next   = magnitude_reg;
        minus_seen_next  = minus_seen_reg;
        digits_ok_next   = digits_ok_reg;
        digit_count_next = digit_count_reg;
        if (take)
        begin
            if (!in_frame_reg || is_end)
            begin
                // Open a frame on the start byte, or close the current one.
                // Either way the body state starts over.
                in_frame_next    = !in_frame_reg && (byte_in == start_char);
                if (in_frame_reg || (byte_in == start_char))
                begin
                    body_count_next  = '0;
                    kw_shift_next    = '0;
                    magnitude_next   = '0;
                    minus_seen_next  = 1'b0;
                    digits_ok_next   = 1'b1;
                    digit_count_next = '0;
                end
            end
            else
            begin
                if (body_count_reg < KwLen)
                begin
                    kw_shift_next = {kw_shift_reg[23:0], byte_in};
                end
                else if ((byte_in == CHAR_MINUS) && (body_count_reg == KwLen))
                begin
                    minus_seen_next = 1'b1;
                end
                else if (is_digit)
                begin
                    if (digit_count_reg < MaxDig)
                    begin
                        magnitude_next = mag_times_ten + 30'(digit_val);
                    end
                    if (digit_count_reg <= MaxDig)
                    begin
                        digit_count_next = digit_count_reg + 4'd1;
                    end
                end
                else
                begin
                    digits_ok_next = 1'b0;
                end
                if (body_count_reg < MaxBody)
                begin
                    body_count_next = body_count_reg + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            body_count_reg  <= '0;
            kw_shift_reg    <= '0;
            magnitude_reg   <= '0;
            minus_seen_reg  <= 1'b0;
            digits_ok_reg   <= 1'b1;
            digit_count_reg <= '0;
        end
        else
        begin
            in_frame_reg    <= in_frame_next;
            body_count_reg  <= body_count_next;
            kw_shift_reg    <= kw_shift_next;
            magnitude_reg   <= magnitude_next;
            minus_seen_reg  <= minus_seen_next;
            digits_ok_reg   <= digits_ok_next;
            digit_count_reg <= digit_count_next;
        end
    end

    `FCP_ASSERT_IMPLIES(a_res_in_frame, clk, rst_n, res_valid, in_frame_reg, "result outside a frame")
    `FCP_ASSERT_NEXT(a_close_frame, clk, rst_n, res_valid, !in_frame_reg, "frame stayed open after close")
    `FCP_ASSERT_IMPLIES(a_digit_sat, clk, rst_n, 1'b1, digit_count_reg <= (MaxDig + 4'd1), "digit count ran past saturation")
    `FCP_ASSERT_IMPLIES(a_num_has_cmd, clk, rst_n, res_valid && res.is_numeric, res.cmd_type != CMD_UNDEF, "numeric result without a keyword")
    `FCP_ASSERT_IMPLIES(a_zero_value, clk, rst_n, res_valid && !res.is_numeric, res.value == 31'd0, "non-numeric result with nonzero value")

endmodule

`default_nettype wire

[rtl/core/fcp_out.sv]
// Result register for the framed command parser output stream.
// Depends on fcp_pkg.
`default_nettype none

module fcp_out
    import fcp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire fcp_result_t res,
    input  wire logic        m_tready,
    output logic             m_tvalid,
    output fcp_result_t      res_q,
    output logic             can_take
);

    logic        valid_reg, valid_next;
    fcp_result_t data_reg;

    // A new word may enter whenever the register is empty or is drained now.
    assign can_take = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign res_q    = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

endmodule

`default_nettype wire

[rtl/core/framed_command_parser.sv]
// Top level of the framed command parser: configuration registers, body
// parser and output register. Depends on fcp_pkg, fcp_body and fcp_out.
//
//  Channel  | Dir | Signals                        | Contents
//  ---------+-----+--------------------------------+---------------------------------
//  s_axis   | in  | s_tvalid s_tready s_tdata[7:0] | one received character per word
//  m_axis   | out | m_tvalid m_tready m_tdata[47:0]| one parsed command per frame
//  cfg      | in  | cfg_we cfg_addr cfg_wdata[7:0] | start and end character
//
// A word may be accepted on every clock edge while the output register can
// take a result, so the sustained rate is one character per cycle unless stalled.
// A closing character yields its result in the cycle after acceptance, from the
// output register. All other characters only update the body state.
// The input stalls only when the output register holds a word that the
// downstream side does not take in that same cycle.
// Reset (rst_n low, asynchronous) empties the output register, closes any
// open frame and restores the start and end characters to '#' and newline.
`default_nettype none

module framed_command_parser
    import fcp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream. s_tdata: [7:0] byte_in.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    // Output stream. m_tdata: [2:0] cmd_type, [3] is_numeric, [34:4] value,
    // [42:35] body_length, [47:43] zero.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,
    // Configuration writes: index 0 start_char, index 1 end_char.
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata
);

    logic [7:0]  start_char_reg;
    logic [7:0]  end_char_reg;
    logic        take;
    logic        res_valid;
    fcp_result_t res;
    fcp_result_t res_q;
    logic        can_take;

    // Configuration registers; user to write only while the block is idle, unchecked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_char_reg <= START_CHAR_RESET;
            end_char_reg   <= END_CHAR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_START_CHAR: start_char_reg <= cfg_wdata;
                CFG_END_CHAR:   end_char_reg   <= cfg_wdata;
                default:        start_char_reg <= start_char_reg;
            endcase
        end
    end

    assign s_tready = can_take;
    assign take     = s_tvalid && can_take;

    fcp_body u_body (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .byte_in    (s_tdata),
        .start_char (start_char_reg),
        .end_char   (end_char_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    fcp_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res      (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .res_q    (res_q),
        .can_take (can_take)
    );

    // Pack the result fields, lowest field in the lowest bits.
    assign m_tdata = {5'b0_0000, res_q.body_length, res_q.value, res_q.is_numeric,
                      res_q.cmd_type};

endmodule

`default_nettype wire

[sim/framed_command_parser_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for framed_command_parser: byte stream in, one parsed command
// per frame out, checked against an in-bench parser. Depends on fcp_pkg and the RTL.

module framed_command_parser_test;
    import fcp_pkg::*;

    // Cycles without any accepted word before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to wait once nothing is pending.
    localparam int SETTLE_CYCLES = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // byte_in in [7:0].
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // cmd_type [2:0], is_numeric [3], value [34:4], body_length [42:35], zero above.
    logic [47:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_addr = CFG_START_CHAR;
    logic [7:0]  cfg_wdata = 8'h00;

    // Shadow copy of the parser state, updated on every accepted word.
    logic [7:0]  start_ch = START_CHAR_RESET;
    logic [7:0]  end_ch = END_CHAR_RESET;
    logic        frame_open = 1'b0;
    logic [7:0]  seen_len = 8'd0;
    logic [31:0] kw_bytes = 32'd0;
    logic [29:0] digit_mag = 30'd0;
    logic        neg_sign = 1'b0;
    logic        data_clean = 1'b1;
    logic [3:0]  digit_cnt = 4'd0;

    // Commands that closed frames have produced and that have not come out yet.
    fcp_result_t pending_cmds[$];

    int fail_count = 0;
    int quiet_cycles = 0;
    int sent_bytes = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    framed_command_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // The receiver stalls at random with the current stall rate.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Starts a fresh body: no keyword bytes, no digits, data still valid.
    function void clear_body();
        seen_len   = 8'd0;
        kw_bytes   = 32'd0;
        digit_mag  = 30'd0;
        neg_sign   = 1'b0;
        data_clean = 1'b1;
        digit_cnt  = 4'd0;
    endfunction

    // Feeds one accepted character through the shadow parser. A closing character
    // queues the command that the frame decodes to.
    function void parse_char(input logic [7:0] ch);
        fcp_result_t cmd;
        cmd_t        kind;
        logic [30:0] mag31;
        if (!frame_open)
        begin
            // Anything outside a frame, an end character included, only matters if
            // it is the start character.
            if (ch == start_ch)
            begin
                frame_open = 1'b1;
                clear_body();
            end
        end
        else if (ch != end_ch)
        begin
            if (seen_len < KEYWORD_LEN)
                kw_bytes = {kw_bytes[23:0], ch};
            else if (ch == CHAR_MINUS && seen_len == KEYWORD_LEN)
                neg_sign = 1'b1;
            else if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
            begin
                // Digits past the limit are counted once more so that the frame is
                // marked too long, but they no longer change the magnitude.
                if (digit_cnt < MAX_DIGITS)
                    digit_mag = 30'(digit_mag * 30'd10 + 30'(ch - CHAR_ZERO));
                if (digit_cnt <= MAX_DIGITS)
                    digit_cnt = digit_cnt + 4'd1;
            end
            else
                data_clean = 1'b0;
            if (seen_len < MAX_BODY)
                seen_len = seen_len + 8'd1;
        end
        else
        begin
            kind = CMD_UNDEF;
            if (seen_len >= KEYWORD_LEN)
            begin
                case (kw_bytes)
                    KW_CONT: kind = CMD_CONT;
                    KW_EXTD: kind = CMD_EXTD;
                    KW_STOP: kind = CMD_STOP;
                    KW_PRNT: kind = CMD_PRNT;
                    default: kind = CMD_UNDEF;
                endcase
            end
            cmd.cmd_type    = kind;
            cmd.is_numeric  = (kind != CMD_UNDEF) && data_clean && (digit_cnt <= MAX_DIGITS);
            mag31           = {1'b0, digit_mag};
            cmd.value       = 31'd0;
            if (cmd.is_numeric)
                cmd.value = neg_sign ? (31'd0 - mag31) : mag31;
            cmd.body_length = seen_len;
            pending_cmds.push_back(cmd);
            frame_open = 1'b0;
            clear_body();
        end
    endfunction

    function void check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Monitor: checks every command that leaves, predicts from every character that
    // enters, tracks register writes and runs the watchdog.
    always @(posedge clk)
    begin
        fcp_result_t got;
        fcp_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = fcp_result_t'(m_tdata[42:0]);
                if (pending_cmds.size() == 0)
                begin
                    $error("command word with none pending: %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    check_field("cmd_type", longint'(want.cmd_type), longint'(got.cmd_type));
                    check_field("is_numeric", longint'(want.is_numeric),
                                longint'(got.is_numeric));
                    check_field("value", longint'(want.value), longint'(got.value));
                    check_field("body_length", longint'(want.body_length),
                                longint'(got.body_length));
                end
            end
            if (s_tvalid && s_tready)
                parse_char(s_tdata);
            if (cfg_we)
            begin
                if (cfg_addr == CFG_START_CHAR)
                    start_ch = cfg_wdata;
                else if (cfg_addr == CFG_END_CHAR)
                    end_ch = cfg_wdata;
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Presents one character, waits for it to be taken, then maybe leaves a gap.
    // A gap lowers tvalid on the accepting edge and always ends at a later edge,
    // so the next word never lowers and raises tvalid in the same step.
    task automatic send_byte(input logic [7:0] ch);
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        do
            @(posedge clk);
        while (!s_tready);
        sent_bytes++;
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Holds the input idle until every predicted command has been received.
    task automatic go_quiet();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_cmds.size() != 0);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Registers only change once the block has drained and settled.
    task automatic set_frame_chars(input logic [7:0] open_ch, input logic [7:0] close_ch);
        go_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_START_CHAR, open_ch);
        write_reg(CFG_END_CHAR, close_ch);
    endtask

    // Hand-written frames under the reset characters '#' and newline, covering
    // every keyword and each corner of the number syntax.
    task automatic test_directed_frames();
        // Noise before any frame, a stray newline included, must be ignored.
        send_byte(8'hFF);
        send_byte(8'h00);
        send_text("\n");
        send_text("#CONT123\n");
        send_text("#EXTD-45\n");
        send_text("#STOP\n");              // no data reads as zero
        send_text("#PRNT-\n");             // a minus on its own also reads as zero
        send_text("#CONT12-3\n");          // minus after a digit spoils the number
        send_text("#EXTD--5\n");
        send_text("#STOP999999999\n");     // largest value that fits the digit limit
        send_text("#PRNT-999999999\n");
        send_text("#CONT1234567890\n");    // one digit too many
        send_text("#STOP007\n");
        send_text("#AB\n");                // body shorter than a keyword
        send_text("#\n");                  // empty body
        send_text("#XYZW5\n");             // unknown keyword
        send_text("#cont5\n");             // keywords are case sensitive
        send_text("#CONT#1\n");            // a start character inside is plain body
        send_text("#EXTD");
        send_byte(8'hFF);
        send_byte(8'h00);
        send_text("\n");
    endtask

    // A body just longer than the length counter can hold; parsing still sees it all.
    task automatic test_long_body();
        snk_stall_pct = 45;
        send_text("#CONT");
        repeat (252) send_byte(CHAR_ZERO + 8'd7);
        send_text("\n");
        snk_stall_pct = 0;
    endtask

    // Extreme and coinciding frame characters, then back to the reset pair.
    task automatic test_char_settings();
        set_frame_chars(8'h00, 8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_text("EXTD77");
        send_byte(8'hFF);
        set_frame_chars(8'hFF, 8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("STOP-8");
        send_byte(8'h00);
        // With equal characters the first one opens and the next one closes.
        set_frame_chars("|", "|");
        send_text("|PRNT31|");
        send_text("||");
        send_text("|CONT|");
        set_frame_chars(START_CHAR_RESET, END_CHAR_RESET);
        send_text("#CONT-1\n");
    endtask

    // One random frame: mostly a real keyword and a plausible number, sometimes a
    // made-up or short keyword, too many digits, a stray byte, or trailing noise.
    task automatic gen_frame();
        int          sel;
        int          ndig;
        int          noise_at;
        int          i;
        logic [31:0] kw;
        sel = $urandom_range(0, 9);
        send_byte(start_ch);
        if (sel < 8)
        begin
            case (sel / 2)
                0:       kw = KW_CONT;
                1:       kw = KW_EXTD;
                2:       kw = KW_STOP;
                default: kw = KW_PRNT;
            endcase
            for (i = 0; i < KEYWORD_LEN; i++)
                send_byte(kw[31 - 8 * i -: 8]);
        end
        else if (sel == 8)
            repeat (KEYWORD_LEN) send_byte(8'("A" + $urandom_range(0, 25)));
        else
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
        ndig     = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 9);
        noise_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, ndig) : -1;
        if ($urandom_range(0, 2) == 0)
            send_byte(CHAR_MINUS);
        for (i = 0; i <= ndig; i++)
        begin
            if (i == noise_at)
                send_byte($urandom_range(0, 1) ? CHAR_MINUS : 8'($urandom_range(0, 255)));
            if (i < ndig)
                send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        send_byte(end_ch);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Four phases of random frames, each with its own frame characters and its
    // own mix of sender gaps and receiver stalls.
    task automatic test_random_traffic();
        int ph;
        int target;
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    set_frame_chars(START_CHAR_RESET, END_CHAR_RESET);
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    set_frame_chars("<", ">");
                    src_idle_pct  = 45;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    set_frame_chars("|", "|");
                    src_idle_pct  = 0;
                    snk_stall_pct = 45;
                end
                default:
                begin
                    set_frame_chars(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    src_idle_pct  = 10;
                    snk_stall_pct = 10;
                end
            endcase
            target = sent_bytes + 90;
            while (sent_bytes < target)
            begin
                gen_frame();
                // Now and then let the output side empty completely.
                if ($urandom_range(0, 24) == 0)
                    go_quiet();
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_long_body();
        test_char_settings();
        test_random_traffic();
        go_quiet();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
